### hdl/tba_pkg.sv
// ---------------------------------------------------------------------------
// tba_pkg
// Shared types and constants of the temperature band alarm.
// ---------------------------------------------------------------------------
package tba_pkg;

   localparam int SAMPLE_W     = 12;
   localparam int POS_W        = 6;
   localparam int THR_W        = 7;
   localparam int TENTHS_W     = 11;
   localparam int HIST_COUNT_W = 6;
   localparam int CSR_INDEX_W  = 2;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 32;

   // sample*110 compared against threshold*4096
   localparam int SCALE_W      = SAMPLE_W + THR_W;
   localparam int DEG_SCALE    = 110;
   // sample*1100 >> 12 gives tenths of a degree
   localparam int TENTHS_PROD_W = 23;
   localparam int TENTHS_MUL    = 1100;
   localparam int TENTHS_SHIFT  = 12;

   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_READ = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_WARNING  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRITICAL = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL    = 2'd3;

   localparam logic [THR_W-1:0] WARNING_RESET  = 7'd30;
   localparam logic [THR_W-1:0] HIGH_RESET     = 7'd50;
   localparam logic [THR_W-1:0] CRITICAL_RESET = 7'd80;
   localparam logic [THR_W-1:0] LEVEL_RESET    = 7'd100;

   localparam logic [1:0] BAND_NORMAL   = 2'd0;
   localparam logic [1:0] BAND_WARNING  = 2'd1;
   localparam logic [1:0] BAND_HIGH     = 2'd2;
   localparam logic [1:0] BAND_CRITICAL = 2'd3;

   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_ON   = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   localparam logic [1:0] MOTOR_NONE  = 2'd0;
   localparam logic [1:0] MOTOR_OPEN  = 2'd1;
   localparam logic [1:0] MOTOR_CLOSE = 2'd2;

   typedef struct packed {
      logic [THR_W-1:0] warning_threshold;
      logic [THR_W-1:0] high_threshold;
      logic [THR_W-1:0] critical_threshold;
   } cfg_type;

   typedef struct packed {
      logic [1:0]          band;
      logic                alarm_raised;
      logic                alarm_cleared;
      logic [1:0]          cooler_cmd;
      logic [1:0]          buzzer_cmd;
      logic                buzzer_level_write;
      logic [1:0]          motor_cmd;
      logic [TENTHS_W-1:0] temp_tenths;
   } class_type;

   typedef struct packed {
      logic                    entry_valid;
      logic [HIST_COUNT_W-1:0] history_count;
   } hist_status_type;

endpackage

### hdl/temperature_band_alarm_with_history.sv
// ---------------------------------------------------------------------------
// temperature_band_alarm_with_history
// Classifies converter samples into temperature bands, drives alarm and
// actuator commands, and keeps a ring of recent temperatures.
//
// Channels: req_ takes one item per handshake, either a sample tick or a
// history read (req_tuser). rsp_ gives exactly one result per item, in
// order. csr_ writes the three thresholds and the buzzer level; it is
// always ready and must only be used while no item is in flight.
// An accepted item passes the input register, then the result register,
// where its result stays valid until taken. Throughput: one item per
// cycle while rsp_tready is high, set by the single-pass logic between the
// two registers and the one write or one registered read of the history
// memory per item.
// Stall: while rsp_tready is low the result register holds, the input
// register fills, and req_tready drops once both are full.
// Reset: thresholds return to 30/50/80 degrees, buzzer level to 100, the
// alarm latch clears and the history ring becomes empty. Memory contents
// are not cleared; entries are only returned after they are written.
// ---------------------------------------------------------------------------
module temperature_band_alarm_with_history #(
   parameter int HISTORY_DEPTH = 60
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [11:0] adc_sample, [17:12] read_position, [23:18] zero
   input  logic [tba_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] req_type
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [1:0] band, [2] alarm_raised, [3] alarm_cleared, [5:4] cooler_cmd,
   // [7:6] buzzer_cmd, [8] buzzer_level_write, [10:9] motor_cmd,
   // [21:11] temp_tenths, [22] entry_valid, [28:23] history_count, [31:29] zero
   output logic [tba_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tba_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tba_pkg::THR_W-1:0]          csr_data
);
   import tba_pkg::*;

   cfg_type              cfg_ff;
   logic [THR_W-1:0]     level_ff;
   logic                 latch_ff, latch_in;

   logic                 s1_valid_ff;
   logic                 s1_type_ff;
   logic [SAMPLE_W-1:0]  s1_sample_ff;
   logic [POS_W-1:0]     s1_pos_ff;
   logic                 s1_adv;
   logic                 s1_tick;

   logic                 s2_valid_ff;
   class_type            s2_class_ff;
   hist_status_type      s2_status_ff;
   logic                 s2_read_ff;

   class_type            class_in;
   hist_status_type      status_in;
   logic [TENTHS_W-1:0]  rd_data;
   logic [TENTHS_W-1:0]  out_tenths;

   assign csr_ready = 1'b1;

   assign s1_tick    = (s1_type_ff == REQ_TICK);
   assign s1_adv     = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.warning_threshold  <= WARNING_RESET;
         cfg_ff.high_threshold     <= HIGH_RESET;
         cfg_ff.critical_threshold <= CRITICAL_RESET;
         level_ff                  <= LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_WARNING:  cfg_ff.warning_threshold  <= csr_data;
            CSR_HIGH:     cfg_ff.high_threshold     <= csr_data;
            CSR_CRITICAL: cfg_ff.critical_threshold <= csr_data;
            CSR_LEVEL:    level_ff                  <= csr_data;
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_type_ff   <= req_tuser;
         s1_sample_ff <= req_tdata[SAMPLE_W-1:0];
         s1_pos_ff    <= req_tdata[SAMPLE_W +: POS_W];
      end
   end

   tba_classify u_classify (
      .op_tick    (s1_tick),
      .adc_sample (s1_sample_ff),
      .cfg        (cfg_ff),
      .latch      (latch_ff),
      .result     (class_in),
      .latch_in   (latch_in)
   );

   tba_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock       (clock),
      .reset       (reset),
      .op_en       (s1_adv),
      .op_tick     (s1_tick),
      .wr_tenths   (class_in.temp_tenths),
      .rd_position (s1_pos_ff),
      .status      (status_in),
      .rd_data     (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ff <= 1'b0;
      end else if (s1_adv) begin
         latch_ff <= latch_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (!s2_valid_ff || rsp_tready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_class_ff  <= class_in;
         s2_status_ff <= status_in;
         s2_read_ff   <= ~s1_tick;
      end
   end

   // reads take the stored entry, or zero past the stored count
   assign out_tenths = s2_read_ff ? (s2_status_ff.entry_valid ? rd_data : '0)
                                  : s2_class_ff.temp_tenths;

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {3'b000,
                        s2_status_ff.history_count,
                        s2_status_ff.entry_valid,
                        out_tenths,
                        s2_class_ff.motor_cmd,
                        s2_class_ff.buzzer_level_write,
                        s2_class_ff.buzzer_cmd,
                        s2_class_ff.cooler_cmd,
                        s2_class_ff.alarm_cleared,
                        s2_class_ff.alarm_raised,
                        s2_class_ff.band};

endmodule

### hdl/tba_classify.sv
// ---------------------------------------------------------------------------
// tba_classify
// Band decision, alarm latch update and actuator commands for one sample.
// ---------------------------------------------------------------------------
module tba_classify (
   input  logic                           op_tick,
   input  logic [tba_pkg::SAMPLE_W-1:0]   adc_sample,
   input  tba_pkg::cfg_type               cfg,
   input  logic                           latch,
   output tba_pkg::class_type             result,
   output logic                           latch_in
);
   import tba_pkg::*;

   logic [SCALE_W-1:0]       scaled;
   logic [TENTHS_PROD_W-1:0] tenths_prod;
   logic                     above_warning;
   logic                     above_high;
   logic                     above_critical;

   assign scaled      = SCALE_W'(adc_sample) * SCALE_W'(DEG_SCALE);
   assign tenths_prod = TENTHS_PROD_W'(adc_sample) * TENTHS_PROD_W'(TENTHS_MUL);

   assign above_warning  = scaled > {cfg.warning_threshold, {SAMPLE_W{1'b0}}};
   assign above_high     = scaled > {cfg.high_threshold, {SAMPLE_W{1'b0}}};
   assign above_critical = scaled > {cfg.critical_threshold, {SAMPLE_W{1'b0}}};

   always_comb begin
      result   = '0;
      latch_in = latch;
      if (op_tick) begin
         result.temp_tenths = TENTHS_W'(tenths_prod >> TENTHS_SHIFT);
         priority if (above_critical) begin
            result.band               = BAND_CRITICAL;
            result.alarm_raised       = ~latch;
            result.cooler_cmd         = CMD_ON;
            result.buzzer_cmd         = CMD_ON;
            result.buzzer_level_write = 1'b1;
            result.motor_cmd          = MOTOR_CLOSE;
            latch_in                  = 1'b1;
         end else if (above_high) begin
            result.band         = BAND_HIGH;
            result.alarm_raised = ~latch;
            result.cooler_cmd   = CMD_ON;
            result.buzzer_cmd   = CMD_ON;
            result.motor_cmd    = MOTOR_OPEN;
            latch_in            = 1'b1;
         end else if (above_warning) begin
            result.band       = BAND_WARNING;
            result.cooler_cmd = CMD_ON;
            result.buzzer_cmd = CMD_OFF;
         end else begin
            result.band = BAND_NORMAL;
            // clear a raised alarm: shut cooler and buzzer off
            if (latch) begin
               result.alarm_cleared = 1'b1;
               result.cooler_cmd    = CMD_OFF;
               result.buzzer_cmd    = CMD_OFF;
               latch_in             = 1'b0;
            end
         end
      end
   end

endmodule

### hdl/tba_history.sv
// ---------------------------------------------------------------------------
// tba_history
// Ring of converted temperatures: write on ticks, registered read by
// position from the oldest entry.
// ---------------------------------------------------------------------------
module tba_history #(
   parameter int HISTORY_DEPTH = 60
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           op_en,
   input  logic                           op_tick,
   input  logic [tba_pkg::TENTHS_W-1:0]   wr_tenths,
   input  logic [tba_pkg::POS_W-1:0]      rd_position,
   output tba_pkg::hist_status_type       status,
   output logic [tba_pkg::TENTHS_W-1:0]   rd_data
);
   import tba_pkg::*;

   localparam int PTR_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int SUM_W = POS_W + 1;

   logic [TENTHS_W-1:0] mem [HISTORY_DEPTH];
   logic [TENTHS_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]    write_pos_ff, write_pos_in;
   logic [PTR_W-1:0]    oldest_pos_ff, oldest_pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                not_full;
   logic [SUM_W-1:0]    addr_sum;
   logic [SUM_W-1:0]    addr_wrap;
   logic [PTR_W-1:0]    rd_addr;

   assign not_full = count_ff < CNT_W'(HISTORY_DEPTH);

   // position is below the count on any read that matters, so one subtract wraps it
   assign addr_sum  = SUM_W'(oldest_pos_ff) + SUM_W'(rd_position);
   assign addr_wrap = (addr_sum >= SUM_W'(HISTORY_DEPTH)) ?
                      addr_sum - SUM_W'(HISTORY_DEPTH) : addr_sum;
   assign rd_addr   = PTR_W'(addr_wrap);

   always_comb begin
      write_pos_in  = write_pos_ff;
      oldest_pos_in = oldest_pos_ff;
      count_in      = count_ff;
      if (op_tick) begin
         write_pos_in = (write_pos_ff == PTR_W'(HISTORY_DEPTH - 1)) ?
                        '0 : write_pos_ff + PTR_W'(1);
         if (not_full) begin
            count_in = count_ff + CNT_W'(1);
         end else begin
            oldest_pos_in = (oldest_pos_ff == PTR_W'(HISTORY_DEPTH - 1)) ?
                            '0 : oldest_pos_ff + PTR_W'(1);
         end
      end
   end

   assign status.entry_valid   = ~op_tick && (SUM_W'(rd_position) < SUM_W'(count_ff));
   assign status.history_count = HIST_COUNT_W'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         write_pos_ff  <= '0;
         oldest_pos_ff <= '0;
         count_ff      <= '0;
      end else if (op_en) begin
         write_pos_ff  <= write_pos_in;
         oldest_pos_ff <= oldest_pos_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_en && op_tick) begin
         mem[write_pos_ff] <= wr_tenths;
      end
   end

   // hold read data while the result waits downstream
   always_ff @(posedge clock) begin
      if (op_en && !op_tick) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
